>>> rtl/smpr_pkg.sv
package smpr_pkg;

  // request codes carried by req_type
  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_STROBE = 2'd1,
    REQ_READ   = 2'd2
  } req_e;

  // frame phases
  localparam logic [1:0] PHASE_HEADER = 2'd0;
  localparam logic [1:0] PHASE_Y      = 2'd1;
  localparam logic [1:0] PHASE_X      = 2'd2;
  localparam logic [1:0] PHASE_IDLE   = 2'd3;

  // header bit positions and masks
  localparam logic [7:0] HDR_LEFT     = 8'h20;
  localparam logic [7:0] HDR_RIGHT    = 8'h10;
  localparam logic [7:0] DATA_MASK    = 8'h7F;
  localparam logic [3:0] DIR_X_NEG    = 4'hC;
  localparam logic [1:0] DIR_Y_NEG    = 2'h3;
  localparam logic [2:0] LAST_BIT     = 3'd7;

  typedef struct packed {
    logic [7:0] cur_x;
    logic [7:0] cur_y;
    logic [7:0] old_x;
    logic [7:0] old_y;
    logic [1:0] button_bits;
    logic [7:0] move_x;
    logic [7:0] move_y;
    logic [3:0] dir_x;
    logic [1:0] dir_y;
    logic [7:0] frame_byte;
    logic [2:0] bit_index;
    logic [1:0] phase;
    logic       hs_pending;
    logic       active;
    logic       idle_seen;
  } state_t;

  localparam state_t STATE_RESET = '{
    cur_x:       8'd0,
    cur_y:       8'd0,
    old_x:       8'd0,
    old_y:       8'd0,
    button_bits: 2'd0,
    move_x:      8'd0,
    move_y:      8'd0,
    dir_x:       4'd0,
    dir_y:       2'd0,
    frame_byte:  8'd0,
    bit_index:   3'd0,
    phase:       PHASE_IDLE,
    hs_pending:  1'b0,
    active:      1'b0,
    idle_seen:   1'b0
  };

endpackage

>>> rtl/smpr_step.sv
module smpr_step (
  input  logic [1:0]      req_type_i,
  input  logic [7:0]      pos_x_i,
  input  logic [7:0]      pos_y_i,
  input  logic [1:0]      buttons_i,
  input  smpr_pkg::state_t state_i,
  output smpr_pkg::state_t state_o,
  output logic            res_valid_o,
  output logic            res_bit_o
);

  logic [8:0] dx;
  logic [8:0] dy;

  // signed deltas of the two positions
  assign dx = {1'b0, state_i.cur_x} - {1'b0, state_i.old_x};
  assign dy = {1'b0, state_i.cur_y} - {1'b0, state_i.old_y};

  // one item updates the state and may give one serial bit
  always_comb begin
    smpr_pkg::state_t st;
    logic             no_motion;
    logic [2:0]       sel;
    st          = state_i;
    res_valid_o = 1'b0;
    res_bit_o   = 1'b0;
    no_motion   = (state_i.move_x == 8'd0) && (state_i.move_y == 8'd0) &&
                  (state_i.button_bits == 2'd0);
    sel         = 3'd0;
    unique case (req_type_i)
      smpr_pkg::REQ_SAMPLE: begin
        st.old_x       = state_i.cur_x;
        st.old_y       = state_i.cur_y;
        st.cur_x       = pos_x_i;
        st.cur_y       = pos_y_i;
        st.button_bits = buttons_i;
      end
      smpr_pkg::REQ_STROBE: begin
        st.frame_byte = 8'd0;
        st.move_x     = dx[7:0];
        st.move_y     = dy[7:0];
        if (dx[8]) begin
          st.dir_x = smpr_pkg::DIR_X_NEG;
        end else if (dx != 9'd0) begin
          st.dir_x = {1'b0, dx[6], 2'b00};
        end else begin
          st.dir_x = 4'd0;
        end
        if (dy[8]) begin
          st.dir_y = smpr_pkg::DIR_Y_NEG;
        end else if (dy != 9'd0) begin
          st.dir_y = {1'b0, dy[6]};
        end else begin
          st.dir_y = 2'd0;
        end
      end
      smpr_pkg::REQ_READ: begin
        res_valid_o = 1'b1;
        if (no_motion) begin
          st.idle_seen = 1'b1;
        end
        if (no_motion && !state_i.active) begin
          // idle mouse answers zero and rearms the start bit
          st.phase      = smpr_pkg::PHASE_IDLE;
          st.frame_byte = 8'd0;
          res_bit_o     = 1'b0;
        end else begin
          st.active = 1'b1;
          if (state_i.hs_pending) begin
            st.hs_pending = 1'b0;
            st.idle_seen  = 1'b0;
            res_bit_o     = 1'b1;
          end else if (state_i.phase == smpr_pkg::PHASE_IDLE) begin
            // start bit
            st.idle_seen = 1'b0;
            st.phase     = smpr_pkg::PHASE_HEADER;
            res_bit_o    = 1'b1;
          end else begin
            // merge this phase's byte into the frame byte
            if (state_i.phase == smpr_pkg::PHASE_HEADER) begin
              if (state_i.button_bits[0]) st.frame_byte = st.frame_byte | smpr_pkg::HDR_LEFT;
              if (state_i.button_bits[1]) st.frame_byte = st.frame_byte | smpr_pkg::HDR_RIGHT;
              st.frame_byte = st.frame_byte | {4'd0, state_i.dir_x} | {6'd0, state_i.dir_y};
            end else if (state_i.phase == smpr_pkg::PHASE_Y) begin
              st.frame_byte = st.frame_byte | (state_i.move_y & smpr_pkg::DATA_MASK);
            end else begin
              st.frame_byte = st.frame_byte | (state_i.move_x & smpr_pkg::DATA_MASK);
            end
            if (state_i.bit_index == smpr_pkg::LAST_BIT) begin
              // end of byte: advance phase; a handshake bit follows unless the frame ends
              st.bit_index  = 3'd0;
              st.phase      = state_i.phase + 2'd1;
              st.hs_pending = 1'b1;
              res_bit_o     = 1'b0;
              if (st.phase == smpr_pkg::PHASE_IDLE) begin
                st.hs_pending = 1'b0;
                st.active     = 1'b0;
              end
              if (st.idle_seen) begin
                st.idle_seen  = 1'b0;
                st.hs_pending = 1'b0;
                st.active     = 1'b0;
                st.phase      = smpr_pkg::PHASE_IDLE;
                res_bit_o     = 1'b1;
              end
            end else begin
              // data bits go out msb first, inverted
              sel          = 3'd6 - state_i.bit_index;
              res_bit_o    = ~st.frame_byte[sel];
              st.bit_index = state_i.bit_index + 3'd1;
            end
          end
        end
      end
      default: begin
        st = state_i;
      end
    endcase
    state_o = st;
  end

endmodule

>>> rtl/serial_mouse_port_reader.sv
// a read beat's bit passes through the input register and then the result register
// throughput: one item per cycle; the input register and the result register
// stall only when a read result waits in a full result register
// reset: rst_ni is asynchronous, active low; it empties both registers and sets
// the mouse state to all zero with the frame phase idle, start bit pending
module serial_mouse_port_reader (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] req_type_i,
  input  logic [7:0] pos_x_i,
  input  logic [7:0] pos_y_i,
  input  logic [1:0] buttons_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       read_bit_o
);

  logic             in_valid_q;
  logic [1:0]       req_q;
  logic [7:0]       pos_x_q;
  logic [7:0]       pos_y_q;
  logic [1:0]       buttons_q;
  smpr_pkg::state_t state_q;
  smpr_pkg::state_t state_d;
  logic             res_valid;
  logic             res_bit;
  logic             advance;
  logic             out_valid_q;
  logic             out_bit_q;

  // state update for the registered item
  smpr_step u_step (
    .req_type_i (req_q),
    .pos_x_i    (pos_x_q),
    .pos_y_i    (pos_y_q),
    .buttons_i  (buttons_q),
    .state_i    (state_q),
    .state_o    (state_d),
    .res_valid_o(res_valid),
    .res_bit_o  (res_bit)
  );

  // item leaves the input register unless its result has nowhere to go
  assign advance    = in_valid_q && (!res_valid || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // input payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q     <= req_type_i;
      pos_x_q   <= pos_x_i;
      pos_y_q   <= pos_y_i;
      buttons_q <= buttons_i;
    end
  end

  // mouse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smpr_pkg::STATE_RESET;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_bit_q <= res_bit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_bit_o  = out_bit_q;

  // an empty result register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with empty result register");

  // a pending handshake bit implies an active frame outside the idle phase
  a_hs_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.hs_pending |-> (state_q.active && state_q.phase != smpr_pkg::PHASE_IDLE))
    else $error("handshake pending outside an active frame");

  // only a read beat loads the result register
  a_result_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q && !(advance && req_q == smpr_pkg::REQ_READ)) |=> !out_valid_q)
    else $error("result produced without a read beat");

  // the mouse state holds while an item is stalled
  a_state_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (state_q == $past(state_q)))
    else $error("state changed while the item was stalled");

endmodule

>>> test/tb_serial_mouse_port_reader.sv
module tb_serial_mouse_port_reader;
  timeunit 1ns;
  timeprecision 1ps;

  // request code that the block ignores
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int MAX_WAIT = 6;
  localparam int TARGET_BEATS = 1400;

  // mouse state mirror and expected serial bits
  class mouse_bit_tracker;
    bit [7:0] cur_x, cur_y, old_x, old_y;
    bit [7:0] move_x, move_y, frame_byte;
    bit [1:0] btn, dir_y, phase;
    bit [3:0] dir_x;
    bit [2:0] bit_index;
    bit       hs_pending, active, idle_seen;
    bit       expected_bits[$];
    int       err_count, reads_checked, samples, strobes, frames_sent, idle_answers;

    function new();
      cur_x = 0; cur_y = 0; old_x = 0; old_y = 0;
      move_x = 0; move_y = 0; frame_byte = 0;
      btn = 0; dir_x = 0; dir_y = 0;
      bit_index = 0;
      phase = smpr_pkg::PHASE_IDLE;
      hs_pending = 0; active = 0; idle_seen = 0;
    endfunction

    // deltas and direction bits from the last two samples
    function void take_strobe();
      int a, b, dx, dy;
      bit [7:0] top;
      a = cur_x; b = old_x; dx = a - b;
      a = cur_y; b = old_y; dy = a - b;
      frame_byte = 0;
      move_x = dx[7:0];
      move_y = dy[7:0];
      top = (move_x & 8'hC0) >> 4;
      if (dx > 0) dir_x = top[3:0] & 4'h7;
      else if (dx < 0) dir_x = top[3:0] | smpr_pkg::DIR_X_NEG;
      else dir_x = 4'h0;
      top = (move_y & 8'hC0) >> 6;
      if (dy > 0) dir_y = top[1:0] & 2'h1;
      else if (dy < 0) dir_y = top[1:0] | smpr_pkg::DIR_Y_NEG;
      else dir_y = 2'h0;
    endfunction

    // one serial bit of the frame
    function bit take_read();
      bit [15:0] shifted;
      if (move_x == 0 && move_y == 0 && btn == 0) begin
        idle_seen = 1;
        if (!active) begin
          phase = smpr_pkg::PHASE_IDLE;
          frame_byte = 0;
          idle_answers++;
          return 1'b0;
        end
      end
      active = 1;
      if (hs_pending) begin
        hs_pending = 0;
        idle_seen = 0;
        return 1'b1;
      end
      // start bit
      if (phase == smpr_pkg::PHASE_IDLE) begin
        idle_seen = 0;
        phase = smpr_pkg::PHASE_HEADER;
        return 1'b1;
      end
      // frame byte builds up by or across phases
      case (phase)
        smpr_pkg::PHASE_HEADER: begin
          if (btn[0]) frame_byte |= smpr_pkg::HDR_LEFT;
          if (btn[1]) frame_byte |= smpr_pkg::HDR_RIGHT;
          frame_byte |= {4'h0, dir_x};
          frame_byte |= {6'h00, dir_y};
        end
        smpr_pkg::PHASE_Y: frame_byte |= move_y & smpr_pkg::DATA_MASK;
        default: frame_byte |= move_x & smpr_pkg::DATA_MASK;
      endcase
      // end of byte: handshake, next phase or early stop when idle
      if (bit_index == smpr_pkg::LAST_BIT) begin
        bit_index = 0;
        phase = phase + 2'd1;
        hs_pending = 1;
        if (phase == smpr_pkg::PHASE_IDLE) begin
          hs_pending = 0;
          active = 0;
          frames_sent++;
        end
        if (idle_seen) begin
          idle_seen = 0;
          hs_pending = 0;
          active = 0;
          phase = smpr_pkg::PHASE_IDLE;
          return 1'b1;
        end
        return 1'b0;
      end
      // data bits go out msb first and inverted
      shifted = {8'h00, frame_byte} << bit_index;
      bit_index = bit_index + 3'd1;
      return ~shifted[6];
    endfunction

    function void note_beat(logic [1:0] req, logic [7:0] px, logic [7:0] py,
                            logic [1:0] b);
      case (req)
        smpr_pkg::REQ_SAMPLE: begin
          old_x = cur_x;
          old_y = cur_y;
          cur_x = px;
          cur_y = py;
          btn = b;
          samples++;
        end
        smpr_pkg::REQ_STROBE: begin
          take_strobe();
          strobes++;
        end
        smpr_pkg::REQ_READ: expected_bits.push_back(take_read());
        default: ;
      endcase
    endfunction

    task report(string msg);
      err_count++;
      $display("ERROR @%0t: %s", $time, msg);
    endtask

    task check_bit(logic got);
      bit want;
      if (expected_bits.size() == 0) begin
        report($sformatf("read_bit %b arrived with no read outstanding", got));
      end else begin
        want = expected_bits.pop_front();
        reads_checked++;
        if (got !== want)
          report($sformatf("read %0d: read_bit %b, expected %b", reads_checked, got, want));
      end
    endtask
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [1:0] req_type_i = 2'd0;
  logic [7:0] pos_x_i = 8'd0;
  logic [7:0] pos_y_i = 8'd0;
  logic [1:0] buttons_i = 2'd0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       read_bit_o;

  mouse_bit_tracker tracker;
  int beats_sent;
  bit no_gaps;
  bit paused_once;

  serial_mouse_port_reader dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .buttons_i   (buttons_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .read_bit_o  (read_bit_o)
  );

  // clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // one request beat, with a random gap ahead of it
  task automatic send_beat(input logic [1:0] req, input logic [7:0] px,
                           input logic [7:0] py, input logic [1:0] b);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    pos_x_i    <= px;
    pos_y_i    <= py;
    buttons_i  <= b;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    tracker.note_beat(req, px, py, b);
    if (req != REQ_UNUSED) beats_sent++;
  endtask

  task automatic read_bits(input int n);
    repeat (n) send_beat(smpr_pkg::REQ_READ, 8'($urandom), 8'($urandom), 2'($urandom));
  endtask

  task automatic strobe();
    send_beat(smpr_pkg::REQ_STROBE, 8'($urandom), 8'($urandom), 2'($urandom));
  endtask

  // hold off requests until every read bit has come back
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.expected_bits.size() != 0);
  endtask

  // next position: unchanged, small step, extreme, large step or anywhere
  function automatic logic [7:0] pick_coord(logic [7:0] from);
    case ($urandom_range(0, 5))
      0: return from;
      1: return $urandom_range(0, 1) ? from + 8'($urandom_range(1, 3))
                                     : from - 8'($urandom_range(1, 3));
      2: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      3: return $urandom_range(0, 1) ? from + 8'($urandom_range(64, 127))
                                     : from - 8'($urandom_range(64, 127));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [1:0] pick_buttons();
    return $urandom_range(0, 1) ? 2'b00 : 2'($urandom);
  endfunction

  // mostly sample, strobe and a run of reads; sometimes noise or a broken frame
  task automatic run_sequence();
    int kind;
    int n;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 4))
        send_beat(2'($urandom), 8'($urandom), 8'($urandom), 2'($urandom));
    end else begin
      send_beat(smpr_pkg::REQ_SAMPLE, pick_coord(tracker.cur_x), pick_coord(tracker.cur_y),
                pick_buttons());
      if (kind == 1)
        send_beat(smpr_pkg::REQ_SAMPLE, pick_coord(tracker.cur_x),
                  pick_coord(tracker.cur_y), pick_buttons());
      strobe();
      n = $urandom_range(1, 30);
      // strobe or fresh sample in the middle of a frame
      if (kind == 2) begin
        read_bits($urandom_range(1, n));
        strobe();
      end else if (kind == 3) begin
        read_bits($urandom_range(1, n));
        send_beat(smpr_pkg::REQ_SAMPLE, pick_coord(tracker.cur_x),
                  pick_coord(tracker.cur_y), pick_buttons());
        strobe();
      end
      read_bits(n);
    end
  endtask

  // result side: random stall per beat, then check
  task automatic collect_bits();
    int stall;
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      tracker.check_bit(read_bit_o);
    end
  endtask

  // stimulus
  initial begin
    tracker = new();
    fork
      collect_bits();
    join_none
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle read straight out of reset, then the ignored code
    send_beat(smpr_pkg::REQ_READ, 8'h00, 8'h00, 2'b00);
    send_beat(REQ_UNUSED, 8'hFF, 8'hFF, 2'b11);
    // full-scale negative deltas with both buttons down
    send_beat(smpr_pkg::REQ_SAMPLE, 8'hFF, 8'hFF, 2'b11);
    send_beat(smpr_pkg::REQ_SAMPLE, 8'h00, 8'h00, 2'b11);
    strobe();
    read_bits(9);
    // strobe in mid-frame clears only the frame byte
    strobe();
    read_bits(5);
    // positive deltas of 128 in x and 127 in y, left button only
    send_beat(smpr_pkg::REQ_SAMPLE, 8'h80, 8'h7F, 2'b01);
    strobe();
    read_bits(3);

    while (beats_sent < TARGET_BEATS) begin
      if ($urandom_range(0, 7) == 0) no_gaps = ~no_gaps;
      if (!paused_once && beats_sent >= TARGET_BEATS / 2) begin
        wait_for_drain();
        paused_once = 1'b1;
      end else if ($urandom_range(0, 39) == 0) begin
        wait_for_drain();
      end
      run_sequence();
    end

    in_valid_i <= 1'b0;
    while (tracker.expected_bits.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (tracker.expected_bits.size() != 0)
      tracker.report("read bits still outstanding at end of run");

    $display("covered %0d request beats: %0d samples, %0d strobes, %0d read bits checked",
             beats_sent, tracker.samples, tracker.strobes, tracker.reads_checked);
    $display("%0d complete frames sent, %0d idle reads answered", tracker.frames_sent,
             tracker.idle_answers);
    if (tracker.err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("timeout waiting for the block");
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> files.f
rtl/smpr_pkg.sv
rtl/smpr_step.sv
rtl/serial_mouse_port_reader.sv
test/tb_serial_mouse_port_reader.sv
